// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// ===== design/nbcs_pkg.sv =====
// Shared types, register offsets and decode functions for the config space
`default_nettype none

package nbcs_pkg;

    localparam int CONFIG_DEPTH = 256;
    localparam int ADDR_W       = $clog2(CONFIG_DEPTH);
    localparam int REGION_N     = 9;

    // Register offsets with special handling
    localparam logic [ADDR_W-1:0] REG_STATUS_HI  = 8'h07;
    localparam logic [ADDR_W-1:0] REG_CACHE_CTL  = 8'h50;
    localparam logic [ADDR_W-1:0] REG_SHADOW_EN  = 8'h54;
    localparam logic [ADDR_W-1:0] REG_SHADOW_CTL = 8'h55;
    localparam logic [ADDR_W-1:0] REG_SMRAM_LO   = 8'h5C;
    localparam logic [ADDR_W-1:0] REG_SMRAM_HI   = 8'h5D;
    localparam logic [ADDR_W-1:0] REG_SMRAM_CTL  = 8'h60;
    localparam logic [ADDR_W-1:0] REG_MISC_62    = 8'h62;

    // Window port offsets
    localparam logic [7:0] PORT_INDEX  = 8'h22;
    localparam logic [7:0] PORT_UNLOCK = 8'h23;
    localparam logic [7:0] PORT_DATA   = 8'h24;

    localparam logic [7:0] BUS_IDLE = 8'hFF;

    localparam logic [7:0] W1C_MASK     = 8'hF9;
    localparam logic [7:0] CACHE_KEEP   = 8'hF8;
    localparam logic [7:0] CACHE_FORCE  = 8'h04;
    localparam logic [7:0] MISC62_KEEP  = 8'h03;
    localparam logic [2:0] FUNC_HOST    = 3'd0;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic {ST_IDLE, ST_EXEC} nbcs_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } nbcs_wr_t;

    typedef struct packed {
        logic [REGION_N-1:0] read_mask;
        logic [REGION_N-1:0] write_mask;
        logic                changed;
        logic [11:0]         smm_base;
        logic                outside_smm;
        logic                data_to_bus;
        logic                l2_en;
    } nbcs_status_t;

    function automatic logic [7:0] reset_value(input logic [ADDR_W-1:0] a);
        logic [7:0] v;
        case (a)
            8'h00:   v = 8'h60;
            8'h01:   v = 8'h10;
            8'h02:   v = 8'h81;
            8'h03:   v = 8'h88;
            8'h07:   v = 8'h02;
            8'h08:   v = 8'h04;
            8'h0B:   v = 8'h06;
            8'h52:   v = 8'h01;
            8'h55:   v = 8'h40;
            8'h56:   v = 8'hFF;
            8'h57:   v = 8'h0F;
            8'h58:   v = 8'hFF;
            8'h59:   v = 8'h0F;
            8'h5B:   v = 8'h2C;
            8'h5D:   v = 8'h0F;
            8'h5F:   v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic writable(input logic [ADDR_W-1:0] a);
        logic w;
        case (a)
            8'h04, 8'h05, 8'h0C, 8'h0D, 8'h07,
            8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55,
            8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
            8'h5C, 8'h5D, 8'h5E, 8'h5F,
            8'h60, 8'h61, 8'h62: w = 1'b1;
            default:             w = 1'b0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] write_value(input logic [ADDR_W-1:0] a,
                                               input logic [7:0] old,
                                               input logic [7:0] v);
        logic [7:0] r;
        case (a)
            REG_STATUS_HI: r = old & ~(v & W1C_MASK);
            REG_CACHE_CTL: r = (v & CACHE_KEEP) | CACHE_FORCE;
            REG_MISC_62:   r = v & MISC62_KEEP;
            default:       r = v;
        endcase
        return r;
    endfunction

    function automatic logic [REGION_N-1:0] decode_read(input logic [7:0] r54,
                                                        input logic [7:0] r55);
        logic [REGION_N-1:0] m;
        if (r55[7])
            m = {1'b1, r54[0], r54[7:1]};
        else
            m = '0;
        return m;
    endfunction

    function automatic logic [REGION_N-1:0] decode_write(input logic [7:0] r55);
        return r55[6] ? '0 : '1;
    endfunction

endpackage

`default_nettype wire

// ===== design/nbcs_store.sv =====
// Configuration byte memory with per-entry valid bits over the reset image
`default_nettype none

module nbcs_store
    import nbcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire nbcs_wr_t          wr,
    output logic [7:0]             rd_data
);

    logic [7:0]              mem [CONFIG_DEPTH];
    logic [CONFIG_DEPTH-1:0] valid_reg;
    logic [7:0]              data_reg;
    logic                    hit_reg;
    logic [ADDR_W-1:0]       addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            if (rd_en)
                hit_reg <= valid_reg[rd_addr];
        end
    end

    // Never-written entries read as their reset value
    assign rd_data = hit_reg ? data_reg : reset_value(addr_reg);

endmodule

`default_nettype wire

// ===== design/nbcs_shadow.sv =====
// Mirrors of the shadow, SMRAM and cache registers with region mask decode
`default_nettype none

module nbcs_shadow
    import nbcs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire nbcs_wr_t wr,
    output nbcs_status_t  stat_next
);

    logic [7:0]          r50_reg, r54_reg, r55_reg, r5c_reg, r5d_reg, r60_reg;
    logic [7:0]          r50_next, r54_next, r55_next, r5c_next, r5d_next, r60_next;
    logic [REGION_N-1:0] rmask_reg, wmask_reg, rmask_next, wmask_next;
    logic                touch;

    always_comb
    begin
        r50_next = r50_reg;
        r54_next = r54_reg;
        r55_next = r55_reg;
        r5c_next = r5c_reg;
        r5d_next = r5d_reg;
        r60_next = r60_reg;
        touch    = 1'b0;
        if (wr.en)
        begin
            case (wr.addr)
                REG_CACHE_CTL:  r50_next = wr.data;
                REG_SHADOW_EN:
                begin
                    r54_next = wr.data;
                    touch    = 1'b1;
                end
                REG_SHADOW_CTL:
                begin
                    r55_next = wr.data;
                    touch    = 1'b1;
                end
                REG_SMRAM_LO:   r5c_next = wr.data;
                REG_SMRAM_HI:   r5d_next = wr.data;
                REG_SMRAM_CTL:  r60_next = wr.data;
                default:        touch    = 1'b0;
            endcase
        end
        // Masks are re-decoded only on writes to the shadow registers
        rmask_next = touch ? decode_read(r54_next, r55_next) : rmask_reg;
        wmask_next = touch ? decode_write(r55_next) : wmask_reg;

        stat_next.read_mask   = rmask_next;
        stat_next.write_mask  = wmask_next;
        stat_next.changed     = touch && (rmask_next != rmask_reg || wmask_next != wmask_reg);
        stat_next.smm_base    = {r5d_next[3:0], r5c_next};
        stat_next.outside_smm = r60_next[0];
        stat_next.data_to_bus = r60_next[5];
        stat_next.l2_en       = r50_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r50_reg   <= reset_value(REG_CACHE_CTL);
            r54_reg   <= reset_value(REG_SHADOW_EN);
            r55_reg   <= reset_value(REG_SHADOW_CTL);
            r5c_reg   <= reset_value(REG_SMRAM_LO);
            r5d_reg   <= reset_value(REG_SMRAM_HI);
            r60_reg   <= reset_value(REG_SMRAM_CTL);
            rmask_reg <= decode_read(reset_value(REG_SHADOW_EN), reset_value(REG_SHADOW_CTL));
            wmask_reg <= decode_write(reset_value(REG_SHADOW_CTL));
        end
        else
        begin
            r50_reg   <= r50_next;
            r54_reg   <= r54_next;
            r55_reg   <= r55_next;
            r5c_reg   <= r5c_next;
            r5d_reg   <= r5d_next;
            r60_reg   <= r60_next;
            rmask_reg <= rmask_next;
            wmask_reg <= wmask_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/northbridge_config_space.sv =====
// Host-bridge configuration space: top level with sequencer and output register
//
// Usage:
//   Input channel (in_valid / in_stall) carries one byte access per transaction:
//   op, via_window, func_num, addr, wdata. Output channel (out_valid / out_stall)
//   returns exactly one result transaction per input transaction, in order.
//   In each access the configuration memory is read in the accept cycle
//   (registered read), then the byte is modified, written back and the
//   result registered. A new transaction is accepted only after the current
//   one has committed, as the read-modify-write uses the single memory port pair.
//   While a result waits in the output register under out_stall, one more
//   access can be accepted; it completes once the output register is taken.
//   Reset clears the valid bits of the memory at once, so every entry reads
//   its reset value until first written; the window index, unlock flag,
//   register mirrors and region masks return to their reset state. No
//   clearing pass is needed: the block accepts in the first cycle after reset.
`default_nettype none

module northbridge_config_space
    import nbcs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic                via_window,
    input  wire logic [2:0]          func_num,
    input  wire logic [7:0]          addr,
    input  wire logic [7:0]          wdata,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               rdata,
    output logic [REGION_N-1:0]      shadow_read_internal,
    output logic [REGION_N-1:0]      shadow_write_internal,
    output logic                     shadow_changed,
    output logic [11:0]              smram_base_high,
    output logic                     smram_outside_smm,
    output logic                     smram_data_to_bus,
    output logic                     l2_enable
);

    nbcs_state_t  state_reg, state_next;
    logic         in_accept, out_free, commit;

    logic         op_reg, win_reg;
    logic [2:0]   func_reg;
    logic [7:0]   addr_reg, wdata_reg;

    logic [7:0]   idx_reg, idx_next;
    logic         unlock_reg, unlock_next;

    logic [7:0]   mem_data;
    logic [7:0]   rdata_next;
    nbcs_wr_t     wr;
    nbcs_status_t stat_next;

    logic         out_valid_reg;
    logic [7:0]   rdata_reg;
    nbcs_status_t stat_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_EXEC;
            ST_EXEC: if (out_free)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall = 1'b1;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_EXEC: commit   = out_free;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the accepted transaction for the execute cycle
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= op;
            win_reg   <= via_window;
            func_reg  <= func_num;
            addr_reg  <= addr;
            wdata_reg <= wdata;
        end
    end

    nbcs_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (via_window ? idx_reg : addr),
        .wr      (wr),
        .rd_data (mem_data)
    );

    nbcs_shadow u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .stat_next (stat_next)
    );

    // Execute: read data, window port updates, write-back
    always_comb
    begin
        rdata_next  = BUS_IDLE;
        idx_next    = idx_reg;
        unlock_next = unlock_reg;
        wr.en       = 1'b0;
        wr.addr     = addr_reg;
        wr.data     = write_value(addr_reg, mem_data, wdata_reg);
        if (win_reg)
        begin
            if (op_reg == OP_WRITE)
            begin
                case (addr_reg)
                    PORT_INDEX:  idx_next = wdata_reg;
                    PORT_UNLOCK: if (wdata_reg == {idx_reg[3:0], idx_reg[7:4]})
                                     unlock_next = 1'b1;
                    PORT_DATA:   unlock_next = 1'b0;
                    default:     idx_next = idx_reg;
                endcase
            end
            else
            begin
                case (addr_reg)
                    PORT_INDEX:  rdata_next = idx_reg;
                    PORT_UNLOCK: rdata_next = {idx_reg[3:0], idx_reg[7:4]};
                    PORT_DATA:
                    begin
                        // one read per unlock, then relock
                        if (unlock_reg)
                        begin
                            rdata_next  = mem_data;
                            unlock_next = 1'b0;
                        end
                    end
                    default:     rdata_next = BUS_IDLE;
                endcase
            end
        end
        else if (op_reg == OP_WRITE)
            wr.en = writable(addr_reg);
        else if (func_reg == FUNC_HOST)
            rdata_next = mem_data;
        if (!commit)
        begin
            wr.en       = 1'b0;
            idx_next    = idx_reg;
            unlock_next = unlock_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            unlock_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            unlock_reg <= unlock_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rdata_reg <= rdata_next;
            stat_reg  <= stat_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign rdata                 = rdata_reg;
    assign shadow_read_internal  = stat_reg.read_mask;
    assign shadow_write_internal = stat_reg.write_mask;
    assign shadow_changed        = stat_reg.changed;
    assign smram_base_high       = stat_reg.smm_base;
    assign smram_outside_smm     = stat_reg.outside_smm;
    assign smram_data_to_bus     = stat_reg.data_to_bus;
    assign l2_enable             = stat_reg.l2_en;

endmodule

`default_nettype wire

// ===== design/nbcs_checker.sv =====
// Port-level checker for the configuration space block, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module nbcs_checker
    import nbcs_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [7:0]          rdata,
    input wire logic                shadow_changed
);

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // A stalled result keeps its data
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(rdata) && $stable(shadow_changed))
    // Only a write can change region masks, and writes read back idle bus
    `ASSERT_SAME(a_changed_write, clk, rst_n, out_valid && shadow_changed, rdata == BUS_IDLE)
    // One transaction in flight: input closes right after an accept
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind northbridge_config_space nbcs_checker u_nbcs_checker (.*);

`default_nettype wire
